>>> src/wstfd_pkg.sv
// Shared types and constants for the WebSocket text frame deframer.
// No dependencies.
package wstfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_PAYLOAD  = 2'd0;
  localparam status_t ST_REJECTED = 2'd1;
  localparam status_t ST_TOO_LONG = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  localparam logic [3:0] OPCODE_RESET  = 4'h1;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [6:0] LEN_EXT64     = 7'd127;
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;
  localparam logic [3:0] MASK_BYTES    = 4'd4;

endpackage

>>> src/websocket_text_frame_deframer_top.sv
// WebSocket frame deframer, receive side: header parse, unmask, payload out.
// Depends on wstfd_pkg.
//
// channel  | signals                               | dir
// ---------+---------------------------------------+-----
// config   | cfg_valid cfg_ready cfg_data[3:0]     | in
// input    | in_valid in_ready rx_byte[7:0]        | in
// output   | out_valid out_ready out_byte last_byte status | out
//
// One item per cycle while the output is not stalled: each byte updates the parse state and its
// result, if any, lands in the output register at the same edge.
// The next byte is taken while the output register is empty or being drained.
// Sync active-high reset; accepted_opcode resets to 1 (text).
// A stalled output holds its item and blocks input until taken.
module websocket_text_frame_deframer_top
  import wstfd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_byte,
  output status_t    status
);

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  logic [3:0]             accepted_opcode;
  phase_t                 parse_phase, parse_phase_next;
  logic [3:0]             field_bytes_left, field_bytes_left_next;
  logic [LENGTH_BITS-1:0] payload_remaining, payload_remaining_next;
  logic                   length_overflow, length_overflow_next;
  logic [31:0]            mask_key, mask_key_next;
  logic                   mask_present, mask_present_next;
  logic [1:0]             mask_phase, mask_phase_next;
  logic                   frame_rejected, frame_rejected_next;

  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  status_t    emit_status;
  logic       after_len, finish;
  logic [7:0] key_byte;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign key_byte  = mask_key[{~mask_phase, 3'b000} +: 8];

  always_comb begin
    parse_phase_next       = parse_phase;
    field_bytes_left_next  = field_bytes_left;
    payload_remaining_next = payload_remaining;
    length_overflow_next   = length_overflow;
    mask_key_next          = mask_key;
    mask_present_next      = mask_present;
    mask_phase_next        = mask_phase;
    frame_rejected_next    = frame_rejected;
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_last   = 1'b0;
    emit_status = ST_PAYLOAD;
    after_len   = 1'b0;
    finish      = 1'b0;

    case (parse_phase)
      PH_HDR1: begin
        mask_present_next      = rx_byte[7];
        mask_key_next          = '0;
        payload_remaining_next = '0;
        length_overflow_next   = 1'b0;
        if (rx_byte[6:0] == LEN_EXT16) begin
          field_bytes_left_next = EXT16_BYTES;
          parse_phase_next      = PH_EXTLEN;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          field_bytes_left_next = EXT64_BYTES;
          parse_phase_next      = PH_EXTLEN;
        end else begin
          payload_remaining_next = LENGTH_BITS'(rx_byte[6:0]);
          after_len = 1'b1;
        end
      end
      PH_EXTLEN: begin
        if (payload_remaining[LENGTH_BITS-1 -: 8] != 8'd0)
          length_overflow_next = 1'b1;
        payload_remaining_next = {payload_remaining[LENGTH_BITS-9:0], rx_byte};
        field_bytes_left_next  = field_bytes_left - 4'd1;
        after_len = (field_bytes_left_next == 4'd0);
      end
      PH_MASK: begin
        mask_key_next         = {mask_key[23:0], rx_byte};
        field_bytes_left_next = field_bytes_left - 4'd1;
        finish = (field_bytes_left_next == 4'd0);
      end
      PH_PAYLOAD: begin
        mask_phase_next        = mask_phase + 2'd1;
        payload_remaining_next = payload_remaining - LEN_ONE;
        emit      = 1'b1;
        emit_byte = rx_byte ^ key_byte;
        emit_last = (payload_remaining_next == '0);
        if (emit_last)
          parse_phase_next = PH_HDR0;
      end
      PH_SKIP: begin
        payload_remaining_next = payload_remaining - LEN_ONE;
        if (payload_remaining_next == '0)
          parse_phase_next = PH_HDR0;
      end
      default: begin
        frame_rejected_next    = !(rx_byte[7] && (rx_byte[3:0] == accepted_opcode));
        field_bytes_left_next  = 4'd0;
        payload_remaining_next = '0;
        length_overflow_next   = 1'b0;
        mask_key_next          = '0;
        mask_present_next      = 1'b0;
        mask_phase_next        = 2'd0;
        parse_phase_next       = PH_HDR1;
      end
    endcase

    if (after_len) begin
      if (mask_present_next) begin
        parse_phase_next      = PH_MASK;
        field_bytes_left_next = MASK_BYTES;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      mask_phase_next = 2'd0;
      if (frame_rejected_next || length_overflow_next) begin
        parse_phase_next = (payload_remaining_next != '0) ? PH_SKIP : PH_HDR0;
        emit        = 1'b1;
        emit_status = frame_rejected_next ? ST_REJECTED : ST_TOO_LONG;
      end else if (payload_remaining_next == '0) begin
        parse_phase_next = PH_HDR0;
        emit        = 1'b1;
        emit_status = ST_EMPTY;
      end else begin
        parse_phase_next = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_opcode   <= OPCODE_RESET;
      parse_phase       <= PH_HDR0;
      field_bytes_left  <= 4'd0;
      payload_remaining <= '0;
      length_overflow   <= 1'b0;
      mask_key          <= 32'd0;
      mask_present      <= 1'b0;
      mask_phase        <= 2'd0;
      frame_rejected    <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        accepted_opcode <= cfg_data;
      if (accept) begin
        parse_phase       <= parse_phase_next;
        field_bytes_left  <= field_bytes_left_next;
        payload_remaining <= payload_remaining_next;
        length_overflow   <= length_overflow_next;
        mask_key          <= mask_key_next;
        mask_present      <= mask_present_next;
        mask_phase        <= mask_phase_next;
        frame_rejected    <= frame_rejected_next;
        out_valid         <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte  <= emit_byte;
      last_byte <= emit_last;
      status    <= emit_status;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_PAYLOAD || parse_phase == PH_SKIP) |-> payload_remaining != '0)
    else $error("payload/skip phase with zero remaining length");

  a_field_count: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_EXTLEN || parse_phase == PH_MASK) |-> field_bytes_left != 4'd0)
    else $error("header field phase with no bytes left");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> out_valid)
    else $error("result item lost");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_PAYLOAD) |-> (out_byte == 8'd0 && !last_byte))
    else $error("report item carries payload data");

endmodule

>>> verif/websocket_text_frame_deframer_top_tb.sv
`timescale 1ns / 1ps
// Testbench for websocket_text_frame_deframer_top: frame streams in, unmasked bytes checked
// against a predictor held in a scoreboard class. Depends on wstfd_pkg and the top module.
module websocket_text_frame_deframer_top_tb
  import wstfd_pkg::*;
();

  localparam int LEN_BITS     = 32;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 40;

  typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
    status_t    st;
  } deframed_item_t;

  class frame_scoreboard;
    logic [3:0]          opcode;
    phase_t              phase;
    logic [3:0]          fields_left;
    logic [LEN_BITS-1:0] remaining;
    bit                  too_long;
    logic [31:0]         key;
    bit                  masked;
    logic [1:0]          key_idx;
    bit                  rejected;
    deframed_item_t      expected_q[$];
    int                  errors;

    function new();
      opcode      = OPCODE_RESET;
      phase       = PH_HDR0;
      fields_left = '0;
      remaining   = '0;
      too_long    = 1'b0;
      key         = '0;
      masked      = 1'b0;
      key_idx     = '0;
      rejected    = 1'b0;
      errors      = 0;
    endfunction

    function void set_opcode(logic [3:0] v);
      opcode = v;
    endfunction

    function void push_result(logic [7:0] d, logic l, status_t s);
      deframed_item_t it;
      it.data    = d;
      it.is_last = l;
      it.st      = s;
      expected_q.push_back(it);
    endfunction

    function void header_done();
      key_idx = '0;
      if (rejected || too_long) begin
        push_result(8'h00, 1'b0, rejected ? ST_REJECTED : ST_TOO_LONG);
        if (remaining != 0) phase = PH_SKIP;
        else phase = PH_HDR0;
      end else if (remaining == 0) begin
        push_result(8'h00, 1'b0, ST_EMPTY);
        phase = PH_HDR0;
      end else begin
        phase = PH_PAYLOAD;
      end
    endfunction

    function void length_done();
      if (masked) begin
        phase       = PH_MASK;
        fields_left = MASK_BYTES;
      end else begin
        header_done();
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] k;
      case (phase)
        PH_HDR1: begin
          masked    = b[7];
          key       = '0;
          remaining = '0;
          too_long  = 1'b0;
          if (b[6:0] == LEN_EXT16) begin
            fields_left = EXT16_BYTES;
            phase       = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            fields_left = EXT64_BYTES;
            phase       = PH_EXTLEN;
          end else begin
            remaining = LEN_BITS'(b[6:0]);
            length_done();
          end
        end
        PH_EXTLEN: begin
          if (remaining[LEN_BITS-1 -: 8] != 0) too_long = 1'b1;
          remaining   = {remaining[LEN_BITS-9:0], b};
          fields_left = fields_left - 4'd1;
          if (fields_left == 0) length_done();
        end
        PH_MASK: begin
          key         = {key[23:0], b};
          fields_left = fields_left - 4'd1;
          if (fields_left == 0) header_done();
        end
        PH_PAYLOAD: begin
          k         = key[8*(3-key_idx) +: 8];
          key_idx   = key_idx + 2'd1;
          remaining = remaining - 1'b1;
          push_result(b ^ k, remaining == 0, ST_PAYLOAD);
          if (remaining == 0) phase = PH_HDR0;
        end
        PH_SKIP: begin
          remaining = remaining - 1'b1;
          if (remaining == 0) phase = PH_HDR0;
        end
        default: begin
          rejected    = !(b[7] && b[3:0] == opcode);
          fields_left = '0;
          remaining   = '0;
          too_long    = 1'b0;
          key         = '0;
          masked      = 1'b0;
          key_idx     = '0;
          phase       = PH_HDR1;
        end
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_result(logic [7:0] d, logic l, status_t s);
      deframed_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte=%h last=%b status=%0d", d, l, s));
        return;
      end
      want = expected_q.pop_front();
      if (d !== want.data)
        report_mismatch($sformatf("out_byte %h, expected %h", d, want.data));
      if (l !== want.is_last)
        report_mismatch($sformatf("last_byte %b, expected %b", l, want.is_last));
      if (s !== want.st)
        report_mismatch($sformatf("status %0d, expected %0d", s, want.st));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_byte;
  status_t    status;

  frame_scoreboard sb = new();
  bit tx_calm    = 1'b0;
  bit rx_calm    = 1'b0;
  int stall_hold = 0;
  int bytes_sent = 0;

  websocket_text_frame_deframer_top #(.LENGTH_BITS(LEN_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .status    (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side
  initial begin : sink
    int gap;
    int hold;
    wait (rst == 1'b0);
    forever begin
      if (stall_hold > 0) begin
        hold       = stall_hold;
        stall_hold = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = rx_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_byte, last_byte, status);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_opcode(input logic [3:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_opcode(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input len_mode_t mode,
                            input logic [63:0] len, input bit masked,
                            input logic [31:0] key, input bit extremes = 1'b0);
    logic [6:0] len7;
    case (mode)
      LEN_16:  len7 = LEN_EXT16;
      LEN_64:  len7 = LEN_EXT64;
      default: len7 = len[6:0];
    endcase
    send_byte(hdr0);
    send_byte({masked, len7});
    if (mode == LEN_16)
      for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (mode == LEN_64)
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    for (int unsigned n = 0; n < len[31:0]; n++)
      send_byte(extremes ? (n[0] ? 8'hff : 8'h00) : 8'($urandom));
  endtask

  task automatic rand_frame();
    logic [7:0]  hdr0;
    logic [3:0]  op;
    logic [63:0] len;
    logic [31:0] hi;
    len_mode_t   mode;
    int          sel;
    op   = ($urandom_range(0, 9) != 0) ? sb.opcode : 4'($urandom_range(0, 15));
    hdr0 = {1'($urandom_range(0, 9) != 0), 3'($urandom), op};
    sel  = $urandom_range(0, 19);
    if (sel < 14) begin
      mode = LEN_SHORT;
      len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125))
                                         : 64'($urandom_range(0, 12));
    end else if (sel < 17) begin
      mode = LEN_16;
      len  = 64'($urandom_range(0, 300));
    end else begin
      mode = LEN_64;
      if ($urandom_range(0, 1) == 1) begin
        hi = ($urandom_range(0, 1) == 1) ? $urandom : (32'h1 << $urandom_range(0, 31));
        if (hi == 0) hi = 32'h1;
        len = {hi, 32'($urandom_range(0, 6))};
      end else begin
        len = {32'h0, 32'($urandom_range(0, 40))};
      end
    end
    send_frame(hdr0, mode, len, $urandom_range(0, 2) != 0, $urandom);
  endtask

  // keeps extension fields short so a garbage header never asks for a huge skip
  function automatic logic [7:0] noise_byte();
    if (sb.phase == PH_EXTLEN && sb.fields_left > 4'd1) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(noise_byte());
    while (sb.phase != PH_HDR0) send_byte(noise_byte());
  endtask

  task automatic run_random(input int n_bytes, input bit with_hold);
    int target;
    int frame_no;
    target   = bytes_sent + n_bytes;
    frame_no = 0;
    while (bytes_sent < target) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      if (with_hold && frame_no == 5) begin
        tx_calm    = 1'b1;
        stall_hold = HOLD_CYCLES;
        send_frame({4'h8, sb.opcode}, LEN_SHORT, 64, 1'b1, $urandom);
      end else if (frame_no == 12) begin
        wait_drain();
      end else if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        rand_frame();
      end
      frame_no++;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_frame(8'h81, LEN_SHORT, 5, 1'b1, 32'h37fa213d);
    send_frame(8'h81, LEN_SHORT, 4, 1'b0, 32'h0, 1'b1);
    send_frame(8'h81, LEN_SHORT, 0, 1'b0, 32'h0);
    send_frame(8'h81, LEN_SHORT, 0, 1'b1, 32'h5a5a5a5a);
    send_frame(8'h01, LEN_SHORT, 2, 1'b0, 32'h0);
    send_frame(8'h82, LEN_SHORT, 0, 1'b0, 32'h0);
    send_frame(8'hf1, LEN_SHORT, 2, 1'b1, 32'hffffffff);
    send_frame(8'h81, LEN_16, 3, 1'b1, 32'h01020304);
    send_frame(8'h81, LEN_16, 0, 1'b0, 32'h0);
    send_frame(8'h81, LEN_64, {32'h1, 32'd2}, 1'b1, 32'hdeadbeef);
    send_frame(8'h81, LEN_64, {32'hff000000, 32'd0}, 1'b0, 32'h0);
    send_frame(8'h09, LEN_64, {32'h80000000, 32'd1}, 1'b1, 32'h11223344);
    send_frame(8'h81, LEN_64, 64'd1, 1'b0, 32'h0);

    run_random(400, 1'b1);
    write_opcode(4'h0);
    run_random(400, 1'b0);
    write_opcode(4'hf);
    run_random(400, 1'b0);
    write_opcode(4'($urandom_range(2, 14)));
    run_random(400, 1'b0);

    wait_drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
